FILE: design/fcd_pkg.sv
// Shared types and constants of the FAT cluster chain directory.
// No dependencies; fcd_if and the top-level module use it.
`timescale 1ns / 1ps

package fcd_pkg;

  localparam int DirEntriesDef   = 4;
  localparam int ClusterCountDef = 256;
  localparam int ClusterBytesDef = 4;
  localparam int NameBytesDef    = 8;

  localparam logic [15:0] EndMark  = 16'hFFFF;
  localparam int          YearBase = 1980;
  localparam int          FirstUsable = 2;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_DIR_FULL  = 2'd2,
    STAT_NO_SPACE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] file_name;
    logic [9:0]  byte_count;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } fcd_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  first_cluster;
    logic [9:0]  file_size;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
  } fcd_rsp_t;

endpackage

FILE: design/fcd_if.sv
// Request and response channels of the FAT cluster chain directory.
// Depends on fcd_pkg for the beat types.
`timescale 1ns / 1ps

interface fcd_req_if;
  logic               valid;
  logic               ready;
  fcd_pkg::fcd_req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fcd_rsp_if;
  logic               valid;
  logic               ready;
  fcd_pkg::fcd_rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/fat_cluster_chain_directory_unit.sv
// Top level of the FAT cluster chain directory: sequencer, directory, link table.
// Depends on fcd_pkg, fcd_if and fcd_ram.
`timescale 1ns / 1ps

// One request beat gives one response beat. Requests are taken one at a time.
// The link table lives in a RAM with a registered read; after reset a clearing
// pass writes zero to all CLUSTER_COUNT entries before the first request is
// taken. Lookup, refused requests and unknown ops go from idle straight to the
// response state. Create scans the table up to twice, one entry a cycle. Delete
// walks the chain, reading each link and then clearing it. A finished response
// waits in an output register while the next request is accepted.
module fat_cluster_chain_directory_unit #(
  parameter int DIR_ENTRIES   = fcd_pkg::DirEntriesDef,
  parameter int CLUSTER_COUNT = fcd_pkg::ClusterCountDef,
  parameter int CLUSTER_BYTES = fcd_pkg::ClusterBytesDef,
  parameter int NAME_BYTES    = fcd_pkg::NameBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fcd_req_if.sink  in_i,
  fcd_rsp_if.source out_o
);

  import fcd_pkg::*;

  localparam int CW   = $clog2(CLUSTER_COUNT);
  localparam int AW   = CW + 1;
  localparam int NW   = 8 * NAME_BYTES;
  localparam int SW   = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int AccW = $clog2(1024 + CLUSTER_BYTES);

  localparam logic [AccW-1:0] CbInc     = AccW'(CLUSTER_BYTES);
  localparam logic [AW-1:0]   AddrEnd   = AW'(CLUSTER_COUNT);
  localparam logic [AW-1:0]   AddrLast  = AW'(CLUSTER_COUNT - 1);
  localparam logic [AW-1:0]   AddrFirst = AW'(FirstUsable);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_CCOUNT = 8'b0000_0100,
    ST_CALLOC = 8'b0000_1000,
    ST_CEND   = 8'b0001_0000,
    ST_DREAD  = 8'b0010_0000,
    ST_DWRITE = 8'b0100_0000,
    ST_RESP   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [NW-1:0]   dir_name_q  [DIR_ENTRIES];
  logic [15:0]     dir_date_q  [DIR_ENTRIES];
  logic [15:0]     dir_time_q  [DIR_ENTRIES];
  logic [9:0]      dir_size_q  [DIR_ENTRIES];
  logic [CW-1:0]   dir_first_q [DIR_ENTRIES];

  logic [NW-1:0]   name_q, name_d;
  logic [9:0]      bytes_q, bytes_d;
  logic [15:0]     date_q, date_d, time_q, time_d;
  logic [SW-1:0]   slot_q, slot_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic            pend_vld_q, pend_vld_d;
  logic [CW-1:0]   pend_q, pend_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            any_q, any_d;
  logic [CW-1:0]   prev_q, prev_d, first_q, first_d, cur_q, cur_d;
  logic [AW-1:0]   steps_q, steps_d;
  fcd_rsp_t        res_q, res_d;
  logic            out_vld_q, out_vld_d;
  fcd_rsp_t        out_q, out_d;

  logic            dir_wr, dir_clr;
  logic [SW-1:0]   dir_slot;

  logic            ram_we;
  logic [CW-1:0]   ram_waddr, ram_raddr;
  logic [15:0]     ram_wdata, ram_rdata;

  logic [NW-1:0]   name_in;
  logic [15:0]     date_in, time_in;
  logic            hit, empty_any;
  logic [SW-1:0]   hit_slot, empty_slot;
  logic            free_pend, enough_next;
  logic [AccW-1:0] acc_next;
  logic [15:0]     hit_date, hit_time;

  fcd_ram #(
    .WIDTH(16),
    .DEPTH(CLUSTER_COUNT)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign name_in = in_i.data.file_name[NW-1:0];
  assign date_in = ((16'(in_i.data.year) - 16'(YearBase)) << 9)
                 + (16'(in_i.data.month) << 5) + 16'(in_i.data.day);
  assign time_in = (16'(in_i.data.hour) << 11) + (16'(in_i.data.minute) << 5)
                 + 16'(in_i.data.second[5:1]);

  always_comb begin
    hit        = 1'b0;
    hit_slot   = '0;
    empty_any  = 1'b0;
    empty_slot = '0;
    for (int s = DIR_ENTRIES - 1; s >= 0; s--) begin
      if (dir_name_q[s][NW-1 -: 8] != 8'd0 && dir_name_q[s] == name_in) begin
        hit      = 1'b1;
        hit_slot = SW'(s);
      end
      if (dir_name_q[s][NW-1 -: 8] == 8'd0) begin
        empty_any  = 1'b1;
        empty_slot = SW'(s);
      end
    end
  end

  assign hit_date    = dir_date_q[hit_slot];
  assign hit_time    = dir_time_q[hit_slot];
  assign free_pend   = pend_vld_q && (ram_rdata == 16'd0 || ram_rdata == 16'd1);
  assign acc_next    = acc_q + CbInc;
  assign enough_next = acc_next >= AccW'(bytes_q);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d    = state_q;
    name_d     = name_q;
    bytes_d    = bytes_q;
    date_d     = date_q;
    time_d     = time_q;
    slot_d     = slot_q;
    addr_d     = addr_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    acc_d      = acc_q;
    any_d      = any_q;
    prev_d     = prev_q;
    first_d    = first_q;
    cur_d      = cur_q;
    steps_d    = steps_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_d      = out_q;
    dir_wr     = 1'b0;
    dir_clr    = 1'b0;
    dir_slot   = slot_q;
    ram_we     = 1'b0;
    ram_waddr  = prev_q;
    ram_wdata  = 16'd0;
    ram_raddr  = addr_q[CW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q[CW-1:0];
        addr_d    = addr_q + 1'b1;
        if (addr_q == AddrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          res_d        = '0;
          res_d.status = STAT_NOT_FOUND;
          name_d       = name_in;
          bytes_d      = in_i.data.byte_count;
          date_d       = date_in;
          time_d       = time_in;
          state_d      = ST_RESP;
          unique case (op_e'(in_i.data.op))
            OP_CREATE: begin
              if (name_in[NW-1 -: 8] == 8'd0) begin
                res_d.status = STAT_NOT_FOUND;
              end else if (!empty_any) begin
                res_d.status = STAT_DIR_FULL;
              end else begin
                slot_d     = empty_slot;
                addr_d     = AddrFirst;
                pend_vld_d = 1'b0;
                acc_d      = '0;
                state_d    = ST_CCOUNT;
              end
            end
            OP_DELETE: begin
              if (name_in[NW-1 -: 8] != 8'd0 && hit) begin
                cur_d    = dir_first_q[hit_slot];
                first_d  = dir_first_q[hit_slot];
                steps_d  = '0;
                dir_clr  = 1'b1;
                dir_slot = hit_slot;
                state_d  = ST_DREAD;
              end
            end
            OP_LOOKUP: begin
              if (name_in[NW-1 -: 8] != 8'd0 && hit) begin
                res_d.status        = STAT_OK;
                res_d.first_cluster = 8'(dir_first_q[hit_slot]);
                res_d.file_size     = dir_size_q[hit_slot];
                res_d.out_year      = 12'(hit_date[15:9]) + 12'(YearBase);
                res_d.out_month     = hit_date[8:5];
                res_d.out_day       = hit_date[4:0];
                res_d.out_hour      = hit_time[15:11];
                res_d.out_minute    = hit_time[10:5];
                res_d.out_second    = {hit_time[4:0], 1'b0};
              end
            end
            OP_NONE: begin
              res_d.status = STAT_NOT_FOUND;
            end
          endcase
        end
      end
      ST_CCOUNT: begin
        if (addr_q < AddrEnd) begin
          pend_vld_d = 1'b1;
          pend_d     = addr_q[CW-1:0];
          addr_d     = addr_q + 1'b1;
        end else begin
          pend_vld_d = 1'b0;
        end
        if (free_pend) begin
          acc_d = acc_next;
          if (enough_next) begin
            addr_d     = AddrFirst;
            pend_vld_d = 1'b0;
            acc_d      = '0;
            any_d      = 1'b0;
            state_d    = ST_CALLOC;
          end
        end else if (!pend_vld_q && addr_q == AddrEnd) begin
          res_d.status = STAT_NO_SPACE;
          state_d      = ST_RESP;
        end
      end
      ST_CALLOC: begin
        if (addr_q < AddrEnd) begin
          pend_vld_d = 1'b1;
          pend_d     = addr_q[CW-1:0];
          addr_d     = addr_q + 1'b1;
        end else begin
          pend_vld_d = 1'b0;
        end
        if (free_pend) begin
          acc_d  = acc_next;
          prev_d = pend_q;
          if (!any_q) begin
            first_d = pend_q;
            any_d   = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = 16'(pend_q);
          end
          if (enough_next) begin
            state_d = ST_CEND;
          end
        end
      end
      ST_CEND: begin
        ram_we              = 1'b1;
        ram_wdata           = EndMark;
        dir_wr              = 1'b1;
        res_d.status        = STAT_OK;
        res_d.first_cluster = 8'(first_q);
        state_d             = ST_RESP;
      end
      ST_DREAD: begin
        ram_raddr = cur_q;
        steps_d   = steps_q + 1'b1;
        state_d   = ST_DWRITE;
      end
      ST_DWRITE: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        if (ram_rdata == EndMark || ram_rdata >= 16'(CLUSTER_COUNT)
            || steps_q == AddrEnd) begin
          res_d.status        = STAT_OK;
          res_d.first_cluster = 8'(first_q);
          state_d             = ST_RESP;
        end else begin
          cur_d   = ram_rdata[CW-1:0];
          state_d = ST_DREAD;
        end
      end
      ST_RESP: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      addr_q     <= '0;
      pend_vld_q <= 1'b0;
      any_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int s = 0; s < DIR_ENTRIES; s++) begin
        dir_name_q[s]  <= '0;
        dir_date_q[s]  <= '0;
        dir_time_q[s]  <= '0;
        dir_size_q[s]  <= '0;
        dir_first_q[s] <= '0;
      end
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      pend_vld_q <= pend_vld_d;
      any_q      <= any_d;
      out_vld_q  <= out_vld_d;
      if (dir_wr) begin
        dir_name_q[dir_slot]  <= name_q;
        dir_date_q[dir_slot]  <= date_q;
        dir_time_q[dir_slot]  <= time_q;
        dir_size_q[dir_slot]  <= bytes_q;
        dir_first_q[dir_slot] <= first_q;
      end else if (dir_clr) begin
        dir_name_q[dir_slot]  <= '0;
        dir_date_q[dir_slot]  <= '0;
        dir_time_q[dir_slot]  <= '0;
        dir_size_q[dir_slot]  <= '0;
        dir_first_q[dir_slot] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    name_q  <= name_d;
    bytes_q <= bytes_d;
    date_q  <= date_d;
    time_q  <= time_d;
    slot_q  <= slot_d;
    pend_q  <= pend_d;
    acc_q   <= acc_d;
    prev_q  <= prev_d;
    first_q <= first_d;
    cur_q   <= cur_d;
    steps_q <= steps_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule

FILE: design/fcd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
